FILE: rtl/core/normal_pattern_position_sets_defines.svh
// Assertion macros used by the checker file of the block.
`ifndef NORMAL_PATTERN_POSITION_SETS_DEFINES_SVH
`define NORMAL_PATTERN_POSITION_SETS_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define NPS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("normal_pattern_position_sets check failed");

// Next-cycle implication, disabled while reset is held.
`define NPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("normal_pattern_position_sets check failed");

// Next-cycle implication that is also checked during reset.
`define NPS_ASSERT_RESET(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("normal_pattern_position_sets reset check failed");

`endif

FILE: rtl/core/nps_pkg.sv
`timescale 1ns / 1ps

package nps_pkg;

    localparam int MAX_PIECES = 64;
    localparam int MAX_DIM    = 1024;

    localparam int POS_W  = 11;
    localparam int PCNT_W = $clog2(MAX_PIECES + 1);
    localparam int PIDX_W = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;
    localparam int ADDR_W = $clog2(MAX_DIM + 1);
    localparam int X_W    = $clog2(MAX_DIM + 2);

    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 24;
    localparam int M_TUSER_W  = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [POS_W-1:0] STOCK_RESET = POS_W'(1024);
    localparam logic [POS_W-1:0] MIN_RESET   = '1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;
    localparam logic AXIS_LENGTH = 1'b0;
    localparam logic AXIS_WIDTH  = 1'b1;

    localparam logic REG_STOCK_LENGTH = 1'b0;
    localparam logic REG_STOCK_WIDTH  = 1'b1;

    localparam logic [1:0] STATUS_BUILD  = 2'd0;
    localparam logic [1:0] STATUS_ANSWER = 2'd1;
    localparam logic [1:0] STATUS_EARLY  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QREAD,
        ST_QDONE,
        ST_BSTART,
        ST_XCHK,
        ST_FETCH,
        ST_LOOK,
        ST_TEST,
        ST_WRITE,
        ST_BDONE
    } state_t;

    typedef struct packed {
        logic ready;
        logic accept;
        logic q_out;
        logic b_start;
        logic x_begin;
        logic look;
        logic i_next;
        logic mark;
        logic x_write;
        logic axis_next;
        logic b_out;
    } cmd_t;

    typedef struct packed {
        logic in_query;
        logic in_last;
        logic x_over;
        logic axis_last;
        logic i_end;
        logic size_fit;
        logic size_exact;
        logic map_bit;
        logic out_free;
    } stat_t;

endpackage

FILE: rtl/core/nps_ram.sv
`timescale 1ns / 1ps

module nps_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/nps_ctrl.sv
`timescale 1ns / 1ps

module nps_ctrl
    import nps_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (stat.in_query) begin
                        state_next = ST_QREAD;
                    end else if (stat.in_last) begin
                        state_next = ST_BSTART;
                    end
                end
            end
            ST_QREAD:  state_next = ST_QDONE;
            ST_QDONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_BSTART: state_next = ST_XCHK;
            ST_XCHK: begin
                if (!stat.x_over) begin
                    state_next = ST_FETCH;
                end else if (stat.axis_last) begin
                    state_next = ST_BDONE;
                end else begin
                    state_next = ST_BSTART;
                end
            end
            ST_FETCH: begin
                state_next = stat.i_end ? ST_WRITE : ST_LOOK;
            end
            ST_LOOK: begin
                if (stat.size_fit && stat.size_exact) begin
                    state_next = ST_WRITE;
                end else if (stat.size_fit) begin
                    state_next = ST_TEST;
                end else begin
                    state_next = ST_FETCH;
                end
            end
            ST_TEST: begin
                state_next = stat.map_bit ? ST_WRITE : ST_FETCH;
            end
            ST_WRITE:  state_next = ST_XCHK;
            ST_BDONE: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.ready  = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_QDONE:  cmd.q_out = stat.out_free;
            ST_BSTART: cmd.b_start = 1'b1;
            ST_XCHK: begin
                cmd.x_begin   = !stat.x_over;
                cmd.axis_next = stat.x_over && !stat.axis_last;
            end
            ST_LOOK: begin
                cmd.mark   = stat.size_fit && stat.size_exact;
                cmd.look   = stat.size_fit && !stat.size_exact;
                cmd.i_next = !stat.size_fit;
            end
            ST_TEST: begin
                cmd.mark   = stat.map_bit;
                cmd.i_next = !stat.map_bit;
            end
            ST_WRITE:  cmd.x_write = 1'b1;
            ST_BDONE:  cmd.b_out = stat.out_free;
            default:   cmd = '0;
        endcase
    end

endmodule

FILE: rtl/core/nps_dp.sv
`timescale 1ns / 1ps

module nps_dp
    import nps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    input  cmd_t                  cmd,
    output stat_t                 stat
);

    logic [POS_W-1:0] in_plen;
    logic [POS_W-1:0] in_pwid;
    logic [POS_W-1:0] in_pos;
    logic             in_kind;
    logic             in_axis;

    logic [POS_W-1:0]  stock_length_reg, stock_length_next;
    logic [POS_W-1:0]  stock_width_reg, stock_width_next;
    logic [PCNT_W-1:0] piece_total_reg, piece_total_next;
    logic [POS_W-1:0]  shortest_reg, shortest_next;
    logic [POS_W-1:0]  narrowest_reg, narrowest_next;
    logic              built_reg, built_next;
    logic              axis_reg, axis_next;
    logic              m_valid_reg, m_valid_next;

    logic              q_axis_reg, q_axis_next;
    logic [POS_W-1:0]  q_pos_reg, q_pos_next;
    logic [X_W-1:0]    x_reg, x_next;
    logic [PCNT_W-1:0] i_reg, i_next;
    logic              hit_reg, hit_next;
    logic [ADDR_W-1:0] bound_len_reg, bound_len_next;
    logic [ADDR_W-1:0] bound_wid_reg, bound_wid_next;
    logic [POS_W-1:0]  count_len_reg, count_len_next;
    logic [POS_W-1:0]  count_wid_reg, count_wid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic              m_reach_reg, m_reach_next;
    logic [POS_W-1:0]  m_lc_reg, m_lc_next;
    logic [POS_W-1:0]  m_wc_reg, m_wc_next;

    logic                 store_we;
    logic [2*POS_W-1:0]   piece_rd;
    logic [POS_W-1:0]     size;
    logic [ADDR_W-1:0]    look_addr;
    logic [ADDR_W-1:0]    map_raddr;
    logic                 len_we;
    logic                 wid_we;
    logic                 len_rd;
    logic                 wid_rd;
    logic [POS_W-1:0]     stock_sel;
    logic [POS_W-1:0]     small_sel;
    logic [POS_W-1:0]     diff;
    logic [ADDR_W-1:0]    bound_calc;
    logic [ADDR_W-1:0]    bound_sel;
    logic [ADDR_W-1:0]    q_bound;
    logic                 q_bit;
    logic                 cfg_we;

    assign in_plen = s_tdata[POS_W-1:0];
    assign in_pwid = s_tdata[2*POS_W-1:POS_W];
    assign in_pos  = s_tdata[3*POS_W-1:2*POS_W];
    assign in_kind = s_tuser[0];
    assign in_axis = s_tuser[1];

    assign store_we = cmd.accept && (in_kind == KIND_LOAD)
                      && (32'(piece_total_reg) < MAX_PIECES);

    nps_ram #(
        .WIDTH (2 * POS_W),
        .DEPTH (MAX_PIECES)
    ) u_piece_ram (
        .clk   (aclk),
        .we    (store_we),
        .waddr (piece_total_reg[PIDX_W-1:0]),
        .wdata ({in_pwid, in_plen}),
        .raddr (i_reg[PIDX_W-1:0]),
        .rdata (piece_rd)
    );

    assign size      = (axis_reg == AXIS_WIDTH) ? piece_rd[2*POS_W-1:POS_W]
                                                : piece_rd[POS_W-1:0];
    assign look_addr = x_reg[ADDR_W-1:0] - ADDR_W'(size);
    assign map_raddr = cmd.look ? look_addr : ADDR_W'(q_pos_reg);
    assign len_we    = cmd.x_write && (axis_reg == AXIS_LENGTH);
    assign wid_we    = cmd.x_write && (axis_reg == AXIS_WIDTH);

    nps_ram #(
        .WIDTH (1),
        .DEPTH (MAX_DIM + 1)
    ) u_len_map (
        .clk   (aclk),
        .we    (len_we),
        .waddr (x_reg[ADDR_W-1:0]),
        .wdata (hit_reg),
        .raddr (map_raddr),
        .rdata (len_rd)
    );

    nps_ram #(
        .WIDTH (1),
        .DEPTH (MAX_DIM + 1)
    ) u_wid_map (
        .clk   (aclk),
        .we    (wid_we),
        .waddr (x_reg[ADDR_W-1:0]),
        .wdata (hit_reg),
        .raddr (map_raddr),
        .rdata (wid_rd)
    );

    assign stock_sel = (axis_reg == AXIS_WIDTH) ? stock_width_reg : stock_length_reg;
    assign small_sel = (axis_reg == AXIS_WIDTH) ? narrowest_reg : shortest_reg;
    assign diff      = stock_sel - small_sel;

    always_comb begin
        if (stock_sel < small_sel) begin
            bound_calc = '0;
        end else if (32'(diff) > MAX_DIM) begin
            bound_calc = ADDR_W'(MAX_DIM);
        end else begin
            bound_calc = ADDR_W'(diff);
        end
    end

    assign bound_sel = (axis_reg == AXIS_WIDTH) ? bound_wid_reg : bound_len_reg;
    assign q_bound   = (q_axis_reg == AXIS_WIDTH) ? bound_wid_reg : bound_len_reg;
    assign q_bit     = (q_axis_reg == AXIS_WIDTH) ? wid_rd : len_rd;

    assign stat.in_query   = (in_kind == KIND_QUERY);
    assign stat.in_last    = s_tlast;
    assign stat.x_over     = 32'(x_reg) > 32'(bound_sel);
    assign stat.axis_last  = (axis_reg == AXIS_WIDTH);
    assign stat.i_end      = (i_reg == piece_total_reg);
    assign stat.size_fit   = (size != '0) && (32'(size) <= 32'(x_reg));
    assign stat.size_exact = (32'(size) == 32'(x_reg));
    assign stat.map_bit    = (axis_reg == AXIS_WIDTH) ? wid_rd : len_rd;
    assign stat.out_free   = !m_valid_reg || m_tready;

    assign cfg_we = psel && penable && pwrite;

    always_comb begin
        case (paddr[2])
            REG_STOCK_LENGTH: prdata = CFG_DATA_W'(stock_length_reg);
            REG_STOCK_WIDTH:  prdata = CFG_DATA_W'(stock_width_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb begin
        stock_length_next = stock_length_reg;
        stock_width_next  = stock_width_reg;
        piece_total_next  = piece_total_reg;
        shortest_next     = shortest_reg;
        narrowest_next    = narrowest_reg;
        built_next        = built_reg;
        axis_next         = axis_reg;
        m_valid_next      = m_valid_reg;
        q_axis_next       = q_axis_reg;
        q_pos_next        = q_pos_reg;
        x_next            = x_reg;
        i_next            = i_reg;
        hit_next          = hit_reg;
        bound_len_next    = bound_len_reg;
        bound_wid_next    = bound_wid_reg;
        count_len_next    = count_len_reg;
        count_wid_next    = count_wid_reg;
        m_status_next     = m_status_reg;
        m_reach_next      = m_reach_reg;
        m_lc_next         = m_lc_reg;
        m_wc_next         = m_wc_reg;

        if (cfg_we) begin
            case (paddr[2])
                REG_STOCK_LENGTH: stock_length_next = pwdata[POS_W-1:0];
                REG_STOCK_WIDTH:  stock_width_next  = pwdata[POS_W-1:0];
                default:          stock_length_next = stock_length_reg;
            endcase
        end

        if (cmd.accept) begin
            q_axis_next = in_axis;
            q_pos_next  = in_pos;
        end

        if (store_we) begin
            piece_total_next = piece_total_reg + PCNT_W'(1);
            if (in_plen < shortest_reg) begin
                shortest_next = in_plen;
            end
            if (in_pwid < narrowest_reg) begin
                narrowest_next = in_pwid;
            end
        end

        if (cmd.b_start) begin
            x_next = X_W'(1);
            if (axis_reg == AXIS_WIDTH) begin
                bound_wid_next = bound_calc;
                count_wid_next = POS_W'(1);
            end else begin
                bound_len_next = bound_calc;
                count_len_next = POS_W'(1);
            end
        end

        if (cmd.x_begin) begin
            i_next   = '0;
            hit_next = 1'b0;
        end

        if (cmd.i_next) begin
            i_next = i_reg + PCNT_W'(1);
        end

        if (cmd.mark) begin
            hit_next = 1'b1;
        end

        if (cmd.x_write) begin
            x_next = x_reg + X_W'(1);
            if (hit_reg) begin
                if (axis_reg == AXIS_WIDTH) begin
                    if (count_wid_reg != '1) begin
                        count_wid_next = count_wid_reg + POS_W'(1);
                    end
                end else begin
                    if (count_len_reg != '1) begin
                        count_len_next = count_len_reg + POS_W'(1);
                    end
                end
            end
        end

        if (cmd.axis_next) begin
            axis_next = AXIS_WIDTH;
        end

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cmd.q_out) begin
            m_valid_next  = 1'b1;
            m_status_next = built_reg ? STATUS_ANSWER : STATUS_EARLY;
            m_reach_next  = built_reg && ((q_pos_reg == '0)
                            || ((32'(q_pos_reg) <= 32'(q_bound)) && q_bit));
            m_lc_next     = '0;
            m_wc_next     = '0;
        end

        if (cmd.b_out) begin
            m_valid_next     = 1'b1;
            m_status_next    = STATUS_BUILD;
            m_reach_next     = 1'b0;
            m_lc_next        = count_len_reg;
            m_wc_next        = count_wid_reg;
            built_next       = 1'b1;
            axis_next        = AXIS_LENGTH;
            piece_total_next = '0;
            shortest_next    = MIN_RESET;
            narrowest_next   = MIN_RESET;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stock_length_reg <= STOCK_RESET;
            stock_width_reg  <= STOCK_RESET;
            piece_total_reg  <= '0;
            shortest_reg     <= MIN_RESET;
            narrowest_reg    <= MIN_RESET;
            built_reg        <= 1'b0;
            axis_reg         <= AXIS_LENGTH;
            m_valid_reg      <= 1'b0;
        end else begin
            stock_length_reg <= stock_length_next;
            stock_width_reg  <= stock_width_next;
            piece_total_reg  <= piece_total_next;
            shortest_reg     <= shortest_next;
            narrowest_reg    <= narrowest_next;
            built_reg        <= built_next;
            axis_reg         <= axis_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_axis_reg    <= q_axis_next;
        q_pos_reg     <= q_pos_next;
        x_reg         <= x_next;
        i_reg         <= i_next;
        hit_reg       <= hit_next;
        bound_len_reg <= bound_len_next;
        bound_wid_reg <= bound_wid_next;
        count_len_reg <= count_len_next;
        count_wid_reg <= count_wid_next;
        m_status_reg  <= m_status_next;
        m_reach_reg   <= m_reach_next;
        m_lc_reg      <= m_lc_next;
        m_wc_reg      <= m_wc_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = M_TDATA_W'({m_wc_reg, m_lc_reg, m_reach_reg});

endmodule

FILE: rtl/core/normal_pattern_position_sets.sv
// A load is absorbed on acceptance. A query passes through ST_QREAD and then ST_QDONE,
// where its result is registered once the output is free. A build walks the length map
// and then the width map one position at a time, testing the pieces at each position.
// Loads run at one per cycle while idle; a new query waits for the last result to register.
// Reset: aresetn is synchronous and active low; it clears control state, the piece list
// and the built flag, while the map memories keep their contents until the next build.
`timescale 1ns / 1ps

module normal_pattern_position_sets
    import nps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // piece_length, piece_width, position, zero fill
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // kind, axis
    input  logic [S_TUSER_W-1:0]  s_tuser,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // reachable, length_count, width_count, zero fill
    output logic [M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [M_TUSER_W-1:0]  m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    cmd_t  cmd;
    stat_t stat;

    assign pready   = 1'b1;
    assign s_tready = cmd.ready;

    nps_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    nps_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

FILE: rtl/core/nps_chk.sv
`timescale 1ns / 1ps
`include "normal_pattern_position_sets_defines.svh"

module nps_chk
    import nps_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser
);

    `NPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `NPS_ASSERT_NOW(a_build_fields, m_tvalid && (m_tuser == STATUS_BUILD), (m_tdata[0] == 1'b0) && (m_tdata[11:1] != '0) && (m_tdata[22:12] != '0))
    `NPS_ASSERT_NOW(a_query_fields, m_tvalid && (m_tuser != STATUS_BUILD), m_tdata[22:1] == '0)
    `NPS_ASSERT_NEXT(a_query_busy, s_tvalid && s_tready && (s_tuser[0] == KIND_QUERY), !s_tready)
    `NPS_ASSERT_RESET(a_reset_idle, !aresetn, !m_tvalid)

endmodule

bind normal_pattern_position_sets nps_chk u_nps_chk (.*);
